>>> rtl/alarm_ann_pkg.sv
// ----------------------------------------------------------------------------
// alarm_ann_pkg: shared types and constants of the alarm annunciator
// Command, buzzer source, beep step and register index codes, reset values,
// and the status and result records that move between the modules.
// ----------------------------------------------------------------------------
package alarm_ann_pkg;

	localparam int RECOVERY_WIDTH_DEF = 24;
	localparam int PERIOD_WIDTH_DEF   = 16;
	localparam int CFG_IDX_WIDTH      = 3;

	// register reset values
	localparam int BLINK_PERIOD_RST     = 500;
	localparam int SHORT_BEEP_RST       = 100;
	localparam int SHORT_PAUSE_RST      = 100;
	localparam int ALERT_ON_RST         = 500;
	localparam int ALERT_OFF_RST        = 500;
	localparam int DEFAULT_RECOVERY_RST = 60000;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_STATUS = 2'd1,
		CMD_DOOR   = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_BEEP = 2'd1,
		SRC_DOOR = 2'd2,
		SRC_TEMP = 2'd3
	} src_e;

	typedef enum logic [2:0] {
		BEEP_IDLE = 3'd0,
		BEEP_ON1  = 3'd1,
		BEEP_GAP  = 3'd2,
		BEEP_ON2  = 3'd3,
		BEEP_DONE = 3'd4
	} beep_step_e;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_BLINK_PERIOD     = 3'd0,
		CFG_SHORT_BEEP       = 3'd1,
		CFG_SHORT_PAUSE      = 3'd2,
		CFG_ALERT_ON         = 3'd3,
		CFG_ALERT_OFF        = 3'd4,
		CFG_DEFAULT_RECOVERY = 3'd5
	} cfg_idx_e;

	typedef struct packed {
		logic door_ajar;
		logic door_overdue;
		logic temp_warn;
		logic temp_alarm;
		logic rec_busy;
	} flags_t;

	typedef struct packed {
		logic door_led;
		logic temp_led;
		logic recovery_led;
		logic buzzer;
		src_e buzzer_source;
	} result_t;

	localparam result_t RESULT_RST = '{
		door_led: 1'b0, temp_led: 1'b1, recovery_led: 1'b0,
		buzzer: 1'b0, buzzer_source: SRC_NONE
	};

endpackage

>>> rtl/alarm_ann_if.sv
// ----------------------------------------------------------------------------
// alarm_ann_if: request channels of the alarm annunciator
// Item channel (command and status) and result channel (LED and buzzer levels).
// ----------------------------------------------------------------------------
interface alarm_ann_in_if #(
	parameter int RECOVERY_WIDTH = alarm_ann_pkg::RECOVERY_WIDTH_DEF
);
	logic                      valid;
	logic                      ready;
	logic [1:0]                command;
	logic                      door_ajar;
	logic                      door_overdue;
	logic                      temp_warn;
	logic                      temp_alarm;
	logic                      rec_busy;
	logic [RECOVERY_WIDTH-1:0] recovery_time_ms;

	modport source (
		output valid, command, door_ajar, door_overdue, temp_warn,
		       temp_alarm, rec_busy, recovery_time_ms,
		input  ready
	);
	modport sink (
		input  valid, command, door_ajar, door_overdue, temp_warn,
		       temp_alarm, rec_busy, recovery_time_ms,
		output ready
	);
endinterface

interface alarm_ann_out_if;
	logic       valid;
	logic       ready;
	logic       door_led;
	logic       temp_led;
	logic       recovery_led;
	logic       buzzer;
	logic [1:0] buzzer_source;

	modport source (
		output valid, door_led, temp_led, recovery_led, buzzer, buzzer_source,
		input  ready
	);
	modport sink (
		input  valid, door_led, temp_led, recovery_led, buzzer, buzzer_source,
		output ready
	);
endinterface

>>> rtl/alarm_ann_cfg.sv
// ----------------------------------------------------------------------------
// alarm_ann_cfg: configuration registers
// Six write-only timing registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module alarm_ann_cfg #(
	parameter int RECOVERY_WIDTH = alarm_ann_pkg::RECOVERY_WIDTH_DEF,
	parameter int PERIOD_WIDTH   = alarm_ann_pkg::PERIOD_WIDTH_DEF,
	localparam int DATA_WIDTH    = (RECOVERY_WIDTH > PERIOD_WIDTH) ?
	                               RECOVERY_WIDTH : PERIOD_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [alarm_ann_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0]                  cfg_wdata,
	output logic [PERIOD_WIDTH-1:0]                blink_period,
	output logic [PERIOD_WIDTH-1:0]                short_beep,
	output logic [PERIOD_WIDTH-1:0]                short_pause,
	output logic [PERIOD_WIDTH-1:0]                alert_on,
	output logic [PERIOD_WIDTH-1:0]                alert_off,
	output logic [RECOVERY_WIDTH-1:0]              default_recovery
);

	logic [PERIOD_WIDTH-1:0]   blink_period_q, short_beep_q, short_pause_q;
	logic [PERIOD_WIDTH-1:0]   alert_on_q, alert_off_q;
	logic [RECOVERY_WIDTH-1:0] default_recovery_q;
	logic [PERIOD_WIDTH-1:0]   wdata_p;

	assign wdata_p = cfg_wdata[PERIOD_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q     <= PERIOD_WIDTH'(alarm_ann_pkg::BLINK_PERIOD_RST);
			short_beep_q       <= PERIOD_WIDTH'(alarm_ann_pkg::SHORT_BEEP_RST);
			short_pause_q      <= PERIOD_WIDTH'(alarm_ann_pkg::SHORT_PAUSE_RST);
			alert_on_q         <= PERIOD_WIDTH'(alarm_ann_pkg::ALERT_ON_RST);
			alert_off_q        <= PERIOD_WIDTH'(alarm_ann_pkg::ALERT_OFF_RST);
			default_recovery_q <= RECOVERY_WIDTH'(alarm_ann_pkg::DEFAULT_RECOVERY_RST);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				alarm_ann_pkg::CFG_BLINK_PERIOD:     blink_period_q <= wdata_p;
				alarm_ann_pkg::CFG_SHORT_BEEP:       short_beep_q   <= wdata_p;
				alarm_ann_pkg::CFG_SHORT_PAUSE:      short_pause_q  <= wdata_p;
				alarm_ann_pkg::CFG_ALERT_ON:         alert_on_q     <= wdata_p;
				alarm_ann_pkg::CFG_ALERT_OFF:        alert_off_q    <= wdata_p;
				alarm_ann_pkg::CFG_DEFAULT_RECOVERY: begin
					default_recovery_q <= cfg_wdata[RECOVERY_WIDTH-1:0];
				end
				default: ;
			endcase
		end
	end

	assign blink_period     = blink_period_q;
	assign short_beep       = short_beep_q;
	assign short_pause      = short_pause_q;
	assign alert_on         = alert_on_q;
	assign alert_off        = alert_off_q;
	assign default_recovery = default_recovery_q;

endmodule

>>> rtl/alarm_ann_in_stage.sv
// ----------------------------------------------------------------------------
// alarm_ann_in_stage: input register
// Capture one request per cycle and hold it until the core consumes it.
// ----------------------------------------------------------------------------
module alarm_ann_in_stage #(
	parameter int RECOVERY_WIDTH = alarm_ann_pkg::RECOVERY_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	alarm_ann_in_if.sink              item,
	input  logic                      advance,
	output logic                      fire,
	output logic [1:0]                cmd,
	output alarm_ann_pkg::flags_t     flags,
	output logic [RECOVERY_WIDTH-1:0] rec_time
);

	logic                      valid_s1;
	logic [1:0]                cmd_s1;
	alarm_ann_pkg::flags_t     flags_s1;
	logic [RECOVERY_WIDTH-1:0] rec_time_s1;
	logic                      take;

	// accept when empty, or when the held request moves on this cycle
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;
	assign fire       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1                <= item.command;
			flags_s1.door_ajar    <= item.door_ajar;
			flags_s1.door_overdue <= item.door_overdue;
			flags_s1.temp_warn    <= item.temp_warn;
			flags_s1.temp_alarm   <= item.temp_alarm;
			flags_s1.rec_busy     <= item.rec_busy;
			rec_time_s1           <= item.recovery_time_ms;
		end
	end

	assign cmd      = cmd_s1;
	assign flags    = flags_s1;
	assign rec_time = rec_time_s1;

endmodule

>>> rtl/alarm_ann_core.sv
// ----------------------------------------------------------------------------
// alarm_ann_core: annunciator state and per-request update
// Hold the latched status, blink counters, beep sequencer and alert phases;
// update them for one request and present the resulting levels.
// ----------------------------------------------------------------------------
module alarm_ann_core #(
	parameter int RECOVERY_WIDTH = alarm_ann_pkg::RECOVERY_WIDTH_DEF,
	parameter int PERIOD_WIDTH   = alarm_ann_pkg::PERIOD_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [1:0]                cmd,
	input  alarm_ann_pkg::flags_t     item_flags,
	input  logic [RECOVERY_WIDTH-1:0] rec_time,
	input  logic [PERIOD_WIDTH-1:0]   blink_period,
	input  logic [PERIOD_WIDTH-1:0]   short_beep,
	input  logic [PERIOD_WIDTH-1:0]   short_pause,
	input  logic [PERIOD_WIDTH-1:0]   alert_on,
	input  logic [PERIOD_WIDTH-1:0]   alert_off,
	input  logic [RECOVERY_WIDTH-1:0] default_recovery,
	output alarm_ann_pkg::result_t    result
);

	alarm_ann_pkg::flags_t      flags_q, flags_n;
	logic [RECOVERY_WIDTH-1:0]  rec_len_q, rec_len_n;
	alarm_ann_pkg::result_t     lvl_q, lvl_n;
	logic [PERIOD_WIDTH-1:0]    door_cnt_q, door_cnt_n;
	logic [PERIOD_WIDTH-1:0]    temp_cnt_q, temp_cnt_n;
	alarm_ann_pkg::beep_step_e  step_q, step_n;
	logic [PERIOD_WIDTH-1:0]    beep_cnt_q, beep_cnt_n;
	logic [PERIOD_WIDTH:0]      alert_ph_q, alert_ph_n;
	logic [RECOVERY_WIDTH:0]    tcyc_ph_q, tcyc_ph_n;
	logic [PERIOD_WIDTH:0]      tbeep_ph_q, tbeep_ph_n;

	logic [PERIOD_WIDTH:0]      cyc;
	logic [RECOVERY_WIDTH:0]    tcyc;
	logic [PERIOD_WIDTH:0]      alert_inc, tbeep_inc;
	logic [RECOVERY_WIDTH:0]    tcyc_inc;
	logic                       tick;

	assign cyc       = {1'b0, alert_on} + {1'b0, alert_off};
	assign tcyc      = {rec_len_q, 1'b0};
	assign alert_inc = alert_ph_q + 1'b1;
	assign tbeep_inc = tbeep_ph_q + 1'b1;
	assign tcyc_inc  = tcyc_ph_q + 1'b1;
	assign tick      = fire && (cmd == alarm_ann_pkg::CMD_TICK);

	always_comb begin
		logic [PERIOD_WIDTH-1:0] limit;
		limit      = short_beep;
		flags_n    = flags_q;
		rec_len_n  = rec_len_q;
		lvl_n      = lvl_q;
		door_cnt_n = door_cnt_q;
		temp_cnt_n = temp_cnt_q;
		step_n     = step_q;
		beep_cnt_n = beep_cnt_q;
		alert_ph_n = alert_ph_q;
		tcyc_ph_n  = tcyc_ph_q;
		tbeep_ph_n = tbeep_ph_q;
		case (cmd)
			alarm_ann_pkg::CMD_TICK: begin
				// advance time by one millisecond
				door_cnt_n = (door_cnt_q >= blink_period) ? blink_period : door_cnt_q + 1'b1;
				temp_cnt_n = (temp_cnt_q >= blink_period) ? blink_period : temp_cnt_q + 1'b1;
				beep_cnt_n = (&beep_cnt_q) ? beep_cnt_q : beep_cnt_q + 1'b1;
				alert_ph_n = (alert_inc >= cyc) ? '0 : alert_inc;
				tcyc_ph_n  = (tcyc_inc >= tcyc) ? '0 : tcyc_inc;
				if (tcyc_ph_n == '0) begin
					tbeep_ph_n = '0;
				end else begin
					tbeep_ph_n = (tbeep_inc >= cyc) ? '0 : tbeep_inc;
				end

				// door LED: off, steady, or blinking on timeout
				if (!flags_q.door_ajar) begin
					lvl_n.door_led = 1'b0;
				end else if (!flags_q.door_overdue) begin
					lvl_n.door_led = 1'b1;
				end else if (door_cnt_n >= blink_period) begin
					lvl_n.door_led = !lvl_q.door_led;
					door_cnt_n     = '0;
				end

				// temperature LED: steady, or blinking on warning
				if (!flags_q.temp_warn) begin
					lvl_n.temp_led = 1'b1;
				end else if (temp_cnt_n >= blink_period) begin
					lvl_n.temp_led = !lvl_q.temp_led;
					temp_cnt_n     = '0;
				end

				lvl_n.recovery_led = flags_q.rec_busy;

				// buzzer source by priority
				lvl_n.buzzer_source = alarm_ann_pkg::SRC_NONE;
				lvl_n.buzzer        = 1'b0;
				if (flags_q.door_overdue) begin
					lvl_n.buzzer_source = alarm_ann_pkg::SRC_DOOR;
					lvl_n.buzzer        = alert_ph_n < {1'b0, alert_on};
				end else if (flags_q.temp_alarm) begin
					lvl_n.buzzer_source = alarm_ann_pkg::SRC_TEMP;
					lvl_n.buzzer        = (rec_len_q != '0) &&
					                      (tcyc_ph_n < {1'b0, rec_len_q}) &&
					                      (tbeep_ph_n < {1'b0, alert_on});
				end else if (step_q != alarm_ann_pkg::BEEP_IDLE) begin
					lvl_n.buzzer_source = alarm_ann_pkg::SRC_BEEP;
					if (step_q == alarm_ann_pkg::BEEP_GAP) begin
						limit = short_pause;
					end
					case (step_q)
						alarm_ann_pkg::BEEP_ON1: begin
							if (beep_cnt_n >= limit) begin
								step_n     = alarm_ann_pkg::BEEP_GAP;
								beep_cnt_n = '0;
							end
						end
						alarm_ann_pkg::BEEP_GAP: begin
							if (beep_cnt_n >= limit) begin
								step_n     = alarm_ann_pkg::BEEP_ON2;
								beep_cnt_n = '0;
							end
						end
						alarm_ann_pkg::BEEP_ON2: begin
							if (beep_cnt_n >= limit) begin
								step_n     = alarm_ann_pkg::BEEP_DONE;
								beep_cnt_n = '0;
							end
						end
						default: step_n = alarm_ann_pkg::BEEP_IDLE;
					endcase
					lvl_n.buzzer = (step_n == alarm_ann_pkg::BEEP_ON1) ||
					               (step_n == alarm_ann_pkg::BEEP_ON2);
				end
			end
			alarm_ann_pkg::CMD_STATUS: begin
				// restart the temperature cycle when the alarm rises
				if (item_flags.temp_alarm && !flags_q.temp_alarm) begin
					tcyc_ph_n  = '0;
					tbeep_ph_n = '0;
				end
				flags_n   = item_flags;
				rec_len_n = (rec_time != '0) ? rec_time : default_recovery;
			end
			alarm_ann_pkg::CMD_DOOR: begin
				step_n     = alarm_ann_pkg::BEEP_ON1;
				beep_cnt_n = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q    <= '0;
			rec_len_q  <= RECOVERY_WIDTH'(alarm_ann_pkg::DEFAULT_RECOVERY_RST);
			lvl_q      <= alarm_ann_pkg::RESULT_RST;
			door_cnt_q <= '0;
			temp_cnt_q <= '0;
			step_q     <= alarm_ann_pkg::BEEP_IDLE;
			beep_cnt_q <= '0;
			alert_ph_q <= '0;
			tcyc_ph_q  <= '0;
			tbeep_ph_q <= '0;
		end else if (fire) begin
			flags_q    <= flags_n;
			rec_len_q  <= rec_len_n;
			lvl_q      <= lvl_n;
			door_cnt_q <= door_cnt_n;
			temp_cnt_q <= temp_cnt_n;
			step_q     <= step_n;
			beep_cnt_q <= beep_cnt_n;
			alert_ph_q <= alert_ph_n;
			tcyc_ph_q  <= tcyc_ph_n;
			tbeep_ph_q <= tbeep_ph_n;
		end
	end

	// levels after this request
	assign result = lvl_n;

	a_buzz_has_src: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q.buzzer |-> (lvl_q.buzzer_source != alarm_ann_pkg::SRC_NONE))
		else $error("buzzer on with no source");

	a_door_src: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> ((lvl_q.buzzer_source == alarm_ann_pkg::SRC_DOOR) ==
		          flags_q.door_overdue))
		else $error("door alert source disagrees with timeout flag");

	a_alert_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> ((alert_ph_q == '0) || (alert_ph_q < $past(cyc))))
		else $error("alert phase left its cycle");

	a_door_led_off: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && !flags_q.door_ajar) |=> !lvl_q.door_led)
		else $error("door LED lit with door closed");

endmodule

>>> rtl/alarm_ann_out_reg.sv
// ----------------------------------------------------------------------------
// alarm_ann_out_reg: result register
// Hold one result until the sink takes it.
// ----------------------------------------------------------------------------
module alarm_ann_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  alarm_ann_pkg::result_t result,
	output logic                   advance,
	alarm_ann_out_if.source        levels
);

	logic                   valid_q;
	alarm_ann_pkg::result_t result_q;

	assign advance = !valid_q || levels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (levels.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

	assign levels.valid         = valid_q;
	assign levels.door_led      = result_q.door_led;
	assign levels.temp_led      = result_q.temp_led;
	assign levels.recovery_led  = result_q.recovery_led;
	assign levels.buzzer        = result_q.buzzer;
	assign levels.buzzer_source = result_q.buzzer_source;

endmodule

>>> rtl/alarm_annunciator_top.sv
// ----------------------------------------------------------------------------
// alarm_annunciator_top: LED and buzzer annunciator for a latched alarm status
// Takes tick, status and door-changed requests and returns the LED and buzzer
// levels that hold after each one.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      carries
//  -------   ---   ------------   ----------------------------------------------
//  item      in    valid/ready    command, status flags, recovery_time_ms
//  levels    out   valid/ready    door/temp/recovery LED, buzzer, buzzer_source
//  cfg_*     in    write enable   register index and write data, no read-back
//
//  One request per cycle, sustained, while levels does not stall. Each result
//  passes the input register, then the update logic into the result register.
//  The update is one pass of counter increments and compares over the state
//  registers, so each request finishes as it moves on into the result register.
//  Reset is asynchronous, active low; no clearing pass, ready rises at once.
//  A stall on levels holds the result register; the input register takes one
//  more request, after which item.ready drops until levels drains.
//
module alarm_annunciator_top #(
	parameter int RECOVERY_WIDTH = alarm_ann_pkg::RECOVERY_WIDTH_DEF,
	parameter int PERIOD_WIDTH   = alarm_ann_pkg::PERIOD_WIDTH_DEF,
	localparam int DATA_WIDTH    = (RECOVERY_WIDTH > PERIOD_WIDTH) ?
	                               RECOVERY_WIDTH : PERIOD_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	alarm_ann_in_if.sink                           item,
	alarm_ann_out_if.source                        levels,
	input  logic                                   cfg_wr_en,
	input  logic [alarm_ann_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0]                  cfg_wdata
);

	// timing registers
	logic [PERIOD_WIDTH-1:0]   blink_period, short_beep, short_pause;
	logic [PERIOD_WIDTH-1:0]   alert_on, alert_off;
	logic [RECOVERY_WIDTH-1:0] default_recovery;

	// request held in the input register
	logic                      fire;
	logic                      advance;
	logic [1:0]                cmd;
	alarm_ann_pkg::flags_t     flags;
	logic [RECOVERY_WIDTH-1:0] rec_time;
	alarm_ann_pkg::result_t    result;

	alarm_ann_cfg #(
		.RECOVERY_WIDTH (RECOVERY_WIDTH),
		.PERIOD_WIDTH   (PERIOD_WIDTH)
	) u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.blink_period     (blink_period),
		.short_beep       (short_beep),
		.short_pause      (short_pause),
		.alert_on         (alert_on),
		.alert_off        (alert_off),
		.default_recovery (default_recovery)
	);

	// capture requests; advance when the result register can take one
	alarm_ann_in_stage #(
		.RECOVERY_WIDTH (RECOVERY_WIDTH)
	) u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.advance  (advance),
		.fire     (fire),
		.cmd      (cmd),
		.flags    (flags),
		.rec_time (rec_time)
	);

	// update the state for the held request and compute the new levels
	alarm_ann_core #(
		.RECOVERY_WIDTH (RECOVERY_WIDTH),
		.PERIOD_WIDTH   (PERIOD_WIDTH)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.cmd              (cmd),
		.item_flags       (flags),
		.rec_time         (rec_time),
		.blink_period     (blink_period),
		.short_beep       (short_beep),
		.short_pause      (short_pause),
		.alert_on         (alert_on),
		.alert_off        (alert_off),
		.default_recovery (default_recovery),
		.result           (result)
	);

	// hold the levels until the sink takes them
	alarm_ann_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.result  (result),
		.advance (advance),
		.levels  (levels)
	);

endmodule

>>> tb/tb_alarm_annunciator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alarm_annunciator_top: self-checking bench for the alarm annunciator
// Sends tick, status and door-changed requests over the item channel. A
// cycle-free model of the LEDs, the blink counters, the beep sequence and the
// alert phases predicts the levels after every accepted request. Each result
// on the levels channel is checked in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_alarm_annunciator_top;
	import alarm_ann_pkg::*;

	localparam int         CYCLE_LIMIT     = 300000;
	localparam int         RANDOM_REQUESTS = 530;	// per idling phase, unused codes not counted
	localparam logic [1:0] CMD_UNUSED      = 2'd3;
	localparam flags_t     NO_FLAGS        = '0;
	localparam result_t    DOOR_ALERT_ON   = '{1'b0, 1'b1, 1'b1, 1'b1, SRC_DOOR};
	localparam result_t    DOOR_BEEP_ON    = '{1'b0, 1'b1, 1'b0, 1'b1, SRC_BEEP};

	// One line of the directed plan: a register write or a request. Where
	// typed is set, want is the result read straight off the spec.
	typedef struct packed {
		bit          cfg_write;
		cfg_idx_e    reg_idx;
		logic [23:0] value;		// write data, or recovery_time_ms of a request
		logic [1:0]  cmd;
		flags_t      flags;		// {open, timeout, warning, alarm, recovery}
		bit          typed;
		result_t     want;
	} plan_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_wr_en;
	logic [CFG_IDX_WIDTH-1:0]          cfg_index;
	logic [RECOVERY_WIDTH_DEF-1:0]     cfg_wdata;

	alarm_ann_in_if #(.RECOVERY_WIDTH(RECOVERY_WIDTH_DEF)) item_if ();
	alarm_ann_out_if levels_if ();

	alarm_annunciator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.levels    (levels_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Levels still owed by the block, oldest first.
	result_t levels_due[$];
	int      failures;
	int      src_idle_pct;
	int      snk_idle_pct;

	// Mirror of the registers.
	bit [15:0] blink_ms, beep_ms, pause_ms, on_ms, off_ms;
	bit [23:0] dflt_rec_ms;

	// Mirror of the block state.
	flags_t     flags_q;
	bit [23:0]  rec_len;
	bit         door_lvl, temp_lvl, rec_lvl, buzz_lvl;
	bit [15:0]  door_cnt, temp_cnt;
	beep_step_e step;
	bit [15:0]  step_cnt;
	bit [31:0]  alert_ph, tcyc_ph, tbeep_ph;
	src_e       src_q;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Advance the mirrored state by one request and return the levels held
	// after it. Only a tick moves time and re-evaluates the outputs.
	task automatic annunciate(input logic [1:0] cmd, input flags_t f, input logic [23:0] rt,
			output result_t r);
		bit [31:0] cyc, tcyc, lim;
		bit        on;
		src_e      src;
		cyc  = 32'(on_ms) + 32'(off_ms);
		tcyc = 32'(rec_len) << 1;
		on   = 1'b0;
		src  = SRC_NONE;
		case (cmd)
		CMD_TICK: begin
			// Advance every counter first; blink counters saturate at the period.
			door_cnt = (door_cnt >= blink_ms) ? blink_ms : door_cnt + 16'd1;
			temp_cnt = (temp_cnt >= blink_ms) ? blink_ms : temp_cnt + 16'd1;
			if (step_cnt != 16'hFFFF)
				step_cnt++;
			alert_ph++;
			if (alert_ph >= cyc)
				alert_ph = '0;
			tcyc_ph++;
			if (tcyc_ph >= tcyc)
				tcyc_ph = '0;
			if (tcyc_ph == 0) begin
				tbeep_ph = '0;
			end else begin
				tbeep_ph++;
				if (tbeep_ph >= cyc)
					tbeep_ph = '0;
			end

			// Door LED: off when closed, steady when open, blinking on timeout.
			if (!flags_q.door_ajar) begin
				door_lvl = 1'b0;
			end else if (!flags_q.door_overdue) begin
				door_lvl = 1'b1;
			end else if (door_cnt >= blink_ms) begin
				door_lvl = !door_lvl;
				door_cnt = '0;
			end
			if (!flags_q.temp_warn) begin
				temp_lvl = 1'b1;
			end else if (temp_cnt >= blink_ms) begin
				temp_lvl = !temp_lvl;
				temp_cnt = '0;
			end
			rec_lvl = flags_q.rec_busy;

			// Buzzer source by priority; the beep step holds while outranked.
			if (flags_q.door_overdue) begin
				src = SRC_DOOR;
				on  = alert_ph < on_ms;
			end else if (flags_q.temp_alarm) begin
				src = SRC_TEMP;
				on  = rec_len != 0 && tcyc_ph < rec_len && tbeep_ph < on_ms;
			end else if (step != BEEP_IDLE) begin
				src = SRC_BEEP;
				if (step == BEEP_DONE) begin
					step = BEEP_IDLE;
				end else begin
					lim = (step == BEEP_GAP) ? 32'(pause_ms) : 32'(beep_ms);
					if (step_cnt >= lim) begin
						step     = beep_step_e'(step + 3'd1);
						step_cnt = '0;
					end
					on = step == BEEP_ON1 || step == BEEP_ON2;
				end
			end
			src_q    = src;
			buzz_lvl = on;
		end
		CMD_STATUS: begin
			// A rising temperature alarm restarts the recovery cycle.
			if (f.temp_alarm && !flags_q.temp_alarm) begin
				tcyc_ph  = '0;
				tbeep_ph = '0;
			end
			flags_q = f;
			rec_len = (rt != 0) ? rt : dflt_rec_ms;
		end
		CMD_DOOR: begin
			step     = BEEP_ON1;
			step_cnt = '0;
		end
		default: ;
		endcase
		r = '{door_lvl, temp_lvl, rec_lvl, buzz_lvl, src_q};
	endtask

	// Offer one request, hold it until accepted, then log what it must return.
	// Entered and left at a falling edge.
	task automatic send_request(input logic [1:0] cmd, input flags_t f, input logic [23:0] rt,
			input bit typed, input result_t want);
		result_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			item_if.valid <= 1'b0;
			@(negedge clk);
		end
		item_if.valid            <= 1'b1;
		item_if.command          <= cmd;
		item_if.door_ajar        <= f.door_ajar;
		item_if.door_overdue     <= f.door_overdue;
		item_if.temp_warn        <= f.temp_warn;
		item_if.temp_alarm       <= f.temp_alarm;
		item_if.rec_busy         <= f.rec_busy;
		item_if.recovery_time_ms <= rt;
		do
			@(posedge clk);
		while (!item_if.ready);
		annunciate(cmd, f, rt, r);
		levels_due.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every owed result has come back.
	task automatic settle();
		item_if.valid <= 1'b0;
		while (levels_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write one register; the block must be idle.
	task automatic set_reg(input cfg_idx_e idx, input logic [23:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		case (idx)
		CFG_BLINK_PERIOD:     blink_ms    = v[15:0];
		CFG_SHORT_BEEP:       beep_ms     = v[15:0];
		CFG_SHORT_PAUSE:      pause_ms    = v[15:0];
		CFG_ALERT_ON:         on_ms       = v[15:0];
		CFG_ALERT_OFF:        off_ms      = v[15:0];
		CFG_DEFAULT_RECOVERY: dflt_rec_ms = v;
		default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Drain, load every register with a small random value, then run random
	// requests. Ticks dominate so blink, beep and alert patterns play out.
	task automatic run_phase(input int src_pct, input int snk_pct, input int lo, input int hi);
		cfg_idx_e    idx;
		int          sent;
		int          pick;
		logic [1:0]  cmd;
		flags_t      f;
		logic [23:0] rt;
		settle();
		idx = idx.first();
		do begin
			set_reg(idx, 24'($urandom_range(hi, lo)));
			idx = idx.next();
		end while (idx != idx.first());
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			pick = $urandom_range(99);
			if (pick < 82)
				cmd = CMD_TICK;
			else if (pick < 92)
				cmd = CMD_STATUS;
			else if (pick < 97)
				cmd = CMD_DOOR;
			else
				cmd = CMD_UNUSED;
			f = flags_t'(5'($urandom_range(31)));
			// Keep the door timeout rarer so the door beep gets to finish.
			if ($urandom_range(2) != 0)
				f.door_overdue = 1'b0;
			case ($urandom_range(4))
			0:       rt = '0;
			1:       rt = 24'($urandom);
			default: rt = 24'($urandom_range(9));
			endcase
			send_request(cmd, f, rt, 1'b0, RESULT_RST);
			if (cmd != CMD_UNUSED)
				sent++;
			// Now and then hold the sender until the pipe is empty.
			if ($urandom_range(149) == 0)
				settle();
		end
		settle();
	endtask

	// Receiver: stall at random by the current idle rate.
	initial begin
		levels_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			levels_if.ready <= arst_n && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Check every accepted result against the oldest owed one.
	always @(posedge clk) begin
		result_t due;
		if (arst_n && levels_if.valid && levels_if.ready) begin
			if (levels_due.size() == 0) begin
				$error("levels result with no request outstanding");
				failures++;
			end else begin
				due = levels_due.pop_front();
				if (levels_if.door_led !== due.door_led) begin
					$error("door_led expected %0b got %0b", due.door_led, levels_if.door_led);
					failures++;
				end
				if (levels_if.temp_led !== due.temp_led) begin
					$error("temp_led expected %0b got %0b", due.temp_led, levels_if.temp_led);
					failures++;
				end
				if (levels_if.recovery_led !== due.recovery_led) begin
					$error("recovery_led expected %0b got %0b",
						due.recovery_led, levels_if.recovery_led);
					failures++;
				end
				if (levels_if.buzzer !== due.buzzer) begin
					$error("buzzer expected %0b got %0b", due.buzzer, levels_if.buzzer);
					failures++;
				end
				if (levels_if.buzzer_source !== due.buzzer_source) begin
					$error("buzzer_source expected %0d got %0d",
						due.buzzer_source, levels_if.buzzer_source);
					failures++;
				end
			end
		end
	end

	// Cycle limit: end a hung run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[alarm_annunciator_top] ERROR");
		$finish;
	end

	initial begin
		plan_row_t plan[$];

		// Hold every input at a known value through reset.
		arst_n                   = 1'b0;
		cfg_wr_en                = 1'b0;
		cfg_index                = CFG_BLINK_PERIOD;
		cfg_wdata                = '0;
		item_if.valid            = 1'b0;
		item_if.command          = CMD_TICK;
		item_if.door_ajar        = 1'b0;
		item_if.door_overdue     = 1'b0;
		item_if.temp_warn        = 1'b0;
		item_if.temp_alarm       = 1'b0;
		item_if.rec_busy         = 1'b0;
		item_if.recovery_time_ms = '0;
		failures                 = 0;
		src_idle_pct             = 36;
		snk_idle_pct             = 81;

		// Mirror comes out of reset like the block.
		blink_ms    = 16'(BLINK_PERIOD_RST);
		beep_ms     = 16'(SHORT_BEEP_RST);
		pause_ms    = 16'(SHORT_PAUSE_RST);
		on_ms       = 16'(ALERT_ON_RST);
		off_ms      = 16'(ALERT_OFF_RST);
		dflt_rec_ms = 24'(DEFAULT_RECOVERY_RST);
		flags_q     = NO_FLAGS;
		rec_len     = dflt_rec_ms;
		door_lvl    = 1'b0;
		temp_lvl    = 1'b1;
		rec_lvl     = 1'b0;
		buzz_lvl    = 1'b0;
		door_cnt    = '0;
		temp_cnt    = '0;
		step        = BEEP_IDLE;
		step_cnt    = '0;
		alert_ph    = '0;
		tcyc_ph     = '0;
		tbeep_ph    = '0;
		src_q       = SRC_NONE;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset levels, the unused code, all flags with the widest recovery time.
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b1, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_UNUSED, NO_FLAGS, 1'b1, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'hFFFFFF, CMD_STATUS, 5'b11111, 1'b1,
			RESULT_RST});
		// Timeout outranks all: door alert sounds on the first tick.
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b1, DOOR_ALERT_ON});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_DOOR, NO_FLAGS, 1'b1, DOOR_ALERT_ON});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_STATUS, NO_FLAGS, 1'b1,
			DOOR_ALERT_ON});
		// Flags cleared: the pending door beep takes the buzzer.
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b1, DOOR_BEEP_ON});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h1, CMD_STATUS, 5'b10000, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		// Zero blink period, beep and pause of 1, zero alert cycle, zero default recovery.
		plan.push_back('{1'b1, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b1, CFG_SHORT_BEEP, 24'h1, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b1, CFG_SHORT_PAUSE, 24'h1, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b1, CFG_ALERT_ON, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b1, CFG_ALERT_OFF, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b1, CFG_DEFAULT_RECOVERY, 24'h0, CMD_TICK, NO_FLAGS, 1'b0,
			RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_STATUS, 5'b00110, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h5, CMD_STATUS, 5'b01000, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		// Top of the blink, beep, pause and recovery registers; shortest alert cycle with both phases nonzero.
		plan.push_back('{1'b1, CFG_BLINK_PERIOD, 24'hFFFF, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b1, CFG_SHORT_BEEP, 24'hFFFF, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b1, CFG_SHORT_PAUSE, 24'hFFFF, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b1, CFG_ALERT_ON, 24'h1, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b1, CFG_ALERT_OFF, 24'h1, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b1, CFG_DEFAULT_RECOVERY, 24'hFFFFFF, CMD_TICK, NO_FLAGS, 1'b0,
			RESULT_RST});
		// Rising alarm on the default recovery, then shrink the cycle under it.
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_STATUS, 5'b00010, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h1, CMD_STATUS, 5'b00010, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		// Door beep requested under a timeout stays frozen, then resumes.
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h2, CMD_STATUS, 5'b01000, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_DOOR, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_STATUS, NO_FLAGS, 1'b0, RESULT_RST});
		plan.push_back('{1'b0, CFG_BLINK_PERIOD, 24'h0, CMD_TICK, NO_FLAGS, 1'b0, RESULT_RST});

		// Walk the plan; register writes wait for the pipe to drain.
		foreach (plan[i]) begin
			if (plan[i].cfg_write) begin
				settle();
				set_reg(plan[i].reg_idx, plan[i].value);
			end else begin
				send_request(plan[i].cmd, plan[i].flags, plan[i].value, plan[i].typed,
					plan[i].want);
			end
		end

		// Random requests: receiver-heavy idling, then sender-heavy, then none.
		run_phase(36, 81, 1, 6);
		run_phase(81, 36, 0, 4);
		run_phase(0, 0, 1, 9);

		if (failures == 0 && levels_due.size() == 0)
			$display("[alarm_annunciator_top] OK");
		else
			$display("[alarm_annunciator_top] ERROR");
		$finish;
	end

endmodule
